// ===== rtl/i2cpag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2cpag_pkg - shared types and constants for the im2col address generator
// Size limits, register indexes and the structs passed between the
// configuration block, the position sequencer and the top level.
// ============================================================================
package i2cpag_pkg;

    // Size limits applied to the configuration registers
    localparam logic [9:0] MAX_CHANNELS = 10'd512;
    localparam logic [9:0] MAX_DIM      = 10'd256;
    localparam logic [9:0] MAX_KERNEL   = 10'd11;

    localparam int unsigned SRC_W  = 25;
    localparam int unsigned DEST_W = 32;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHANNELS      = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_IMAGE_WIDTH   = 3'd2,
        REG_KERNEL_SIZE   = 3'd3,
        REG_RESULT_HEIGHT = 3'd4,
        REG_RESULT_WIDTH  = 3'd5,
        REG_PADDING       = 3'd6,
        REG_STEP_SIZE     = 3'd7
    } cfg_reg_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [9:0] nc;
        logic [8:0] ih;
        logic [8:0] iw;
        logic [3:0] ks;
        logic [8:0] rh;
        logic [8:0] rw;
        logic [3:0] pad;
        logic [3:0] step;
    } cfg_t;

    // Current matrix position, restart already applied
    typedef struct packed {
        logic [8:0]        chan;
        logic [3:0]        krow;
        logic [3:0]        kcol;
        logic [7:0]        orow;
        logic [7:0]        ocol;
        logic [SRC_W-1:0]  base;
        logic [DEST_W-1:0] dest;
        logic              last;
    } pos_t;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic logic [9:0] clamp_size(input logic [9:0] v, input logic [9:0] hi);
        logic [9:0] r;
        begin
            r = v;
            if (v == 10'd0)
            begin
                r = 10'd1;
            end
            else if (v > hi)
            begin
                r = hi;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cpag_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2cpag_cfg - configuration registers
// Holds the eight configuration registers; the six size values are presented clamped.
// ============================================================================
module i2cpag_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [9:0]          cfg_data,
    output i2cpag_pkg::cfg_t         cfg
);
    import i2cpag_pkg::*;

    logic [9:0] channels_reg;
    logic [8:0] image_height_reg;
    logic [8:0] image_width_reg;
    logic [3:0] kernel_size_reg;
    logic [8:0] result_height_reg;
    logic [8:0] result_width_reg;
    logic [3:0] padding_reg;
    logic [3:0] step_size_reg;

    logic [9:0] nc_c, ih_c, iw_c, ks_c, rh_c, rw_c;
    cfg_reg_t   idx;

    assign cfg_ready = 1'b1;
    assign idx       = cfg_reg_t'(cfg_index);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg      <= 10'd1;
            image_height_reg  <= 9'd1;
            image_width_reg   <= 9'd1;
            kernel_size_reg   <= 4'd1;
            result_height_reg <= 9'd1;
            result_width_reg  <= 9'd1;
            padding_reg       <= 4'd0;
            step_size_reg     <= 4'd1;
        end
        else if (cfg_valid)
        begin
            case (idx)
                REG_CHANNELS:      channels_reg      <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[8:0];
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[8:0];
                REG_KERNEL_SIZE:   kernel_size_reg   <= cfg_data[3:0];
                REG_RESULT_HEIGHT: result_height_reg <= cfg_data[8:0];
                REG_RESULT_WIDTH:  result_width_reg  <= cfg_data[8:0];
                REG_PADDING:       padding_reg       <= cfg_data[3:0];
                REG_STEP_SIZE:     step_size_reg     <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Clamped sizes
    assign nc_c = clamp_size(channels_reg, MAX_CHANNELS);
    assign ih_c = clamp_size({1'b0, image_height_reg}, MAX_DIM);
    assign iw_c = clamp_size({1'b0, image_width_reg}, MAX_DIM);
    assign ks_c = clamp_size({6'd0, kernel_size_reg}, MAX_KERNEL);
    assign rh_c = clamp_size({1'b0, result_height_reg}, MAX_DIM);
    assign rw_c = clamp_size({1'b0, result_width_reg}, MAX_DIM);

    assign cfg.nc   = nc_c;
    assign cfg.ih   = ih_c[8:0];
    assign cfg.iw   = iw_c[8:0];
    assign cfg.ks   = ks_c[3:0];
    assign cfg.rh   = rh_c[8:0];
    assign cfg.rw   = rw_c[8:0];
    assign cfg.pad  = padding_reg;
    assign cfg.step = step_size_reg;

endmodule
`default_nettype wire

// ===== rtl/i2cpag_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// i2cpag_seq - matrix position sequencer
// Nested channel / kernel row / kernel column / output row / output column
// counters with the running channel base and destination index.
// ============================================================================
module i2cpag_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire i2cpag_pkg::cfg_t cfg,
    input  wire logic             advance,
    input  wire logic             restart,
    output i2cpag_pkg::pos_t      pos
);
    import i2cpag_pkg::*;

    logic [8:0]        chan_count_reg, chan_count_next;
    logic [3:0]        krow_count_reg, krow_count_next;
    logic [3:0]        kcol_count_reg, kcol_count_next;
    logic [7:0]        orow_count_reg, orow_count_next;
    logic [7:0]        ocol_count_reg, ocol_count_next;
    logic [SRC_W-1:0]  channel_base_reg, channel_base_next;
    logic [DEST_W-1:0] out_count_reg, out_count_next;

    logic        end_oc, end_or, end_kc, end_kr, end_c;
    logic [17:0] plane;

    // Current position, rewound by restart
    assign pos.chan = restart ? 9'd0 : chan_count_reg;
    assign pos.krow = restart ? 4'd0 : krow_count_reg;
    assign pos.kcol = restart ? 4'd0 : kcol_count_reg;
    assign pos.orow = restart ? 8'd0 : orow_count_reg;
    assign pos.ocol = restart ? 8'd0 : ocol_count_reg;
    assign pos.base = restart ? '0 : channel_base_reg;
    assign pos.dest = restart ? '0 : out_count_reg;

    // Wrap conditions
    assign end_oc   = ({1'b0, pos.ocol} + 9'd1) >= cfg.rw;
    assign end_or   = ({1'b0, pos.orow} + 9'd1) >= cfg.rh;
    assign end_kc   = ({1'b0, pos.kcol} + 5'd1) >= {1'b0, cfg.ks};
    assign end_kr   = ({1'b0, pos.krow} + 5'd1) >= {1'b0, cfg.ks};
    assign end_c    = ({1'b0, pos.chan} + 10'd1) >= cfg.nc;
    assign pos.last = end_oc && end_or && end_kc && end_kr && end_c;

    assign plane = cfg.ih * cfg.iw;

    // Next position
    always_comb
    begin
        chan_count_next   = pos.chan;
        krow_count_next   = pos.krow;
        kcol_count_next   = pos.kcol;
        orow_count_next   = pos.orow;
        ocol_count_next   = pos.ocol;
        channel_base_next = pos.base;
        out_count_next    = pos.dest + 32'd1;
        if (!end_oc)
        begin
            ocol_count_next = pos.ocol + 8'd1;
        end
        else
        begin
            ocol_count_next = 8'd0;
            if (!end_or)
            begin
                orow_count_next = pos.orow + 8'd1;
            end
            else
            begin
                orow_count_next = 8'd0;
                if (!end_kc)
                begin
                    kcol_count_next = pos.kcol + 4'd1;
                end
                else
                begin
                    kcol_count_next = 4'd0;
                    if (!end_kr)
                    begin
                        krow_count_next = pos.krow + 4'd1;
                    end
                    else
                    begin
                        krow_count_next = 4'd0;
                        if (!end_c)
                        begin
                            chan_count_next   = pos.chan + 9'd1;
                            channel_base_next = pos.base + SRC_W'(plane);
                        end
                        else
                        begin
                            chan_count_next   = 9'd0;
                            channel_base_next = '0;
                            out_count_next    = '0;
                        end
                    end
                end
            end
        end
    end

    // Counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg   <= '0;
            krow_count_reg   <= '0;
            kcol_count_reg   <= '0;
            orow_count_reg   <= '0;
            ocol_count_reg   <= '0;
            channel_base_reg <= '0;
            out_count_reg    <= '0;
        end
        else if (advance)
        begin
            chan_count_reg   <= chan_count_next;
            krow_count_reg   <= krow_count_next;
            kcol_count_reg   <= kcol_count_next;
            orow_count_reg   <= orow_count_next;
            ocol_count_reg   <= ocol_count_next;
            channel_base_reg <= channel_base_next;
            out_count_reg    <= out_count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/im2col_patch_address_gen_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// im2col_patch_address_gen_unit - im2col source address generator
// Emits one column-matrix element per input word: source index or zero
// fill, destination index and an end-of-matrix mark.
// ============================================================================
//
//  Channel   Dir  Handshake             Payload
//  s_axis    in   s_tvalid / s_tready   s_tdata[0] restart
//  m_axis    out  m_tvalid / m_tready   tdata src_index, dest_index;
//                                       tuser zero_fill; tlast last
//  cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One word per cycle sustained while the output is not stalled. The first
//  stage forms the padded row and column (one small multiply each), the
//  second forms row * width + column + channel base (one 8x9 multiply).
//  Reset clears counters and pipeline valids; sizes return to one, padding to zero.
//  A stalled output holds both stages; s_tready follows the output stage.
//  cfg_ready is always high.
//
module im2col_patch_address_gen_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // [24:0] src_index, [56:25] dest_index
    output logic             m_tuser,    // [0] zero_fill
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);
    import i2cpag_pkg::*;

    cfg_t cfg;
    pos_t pos;

    logic advance, enable;

    logic [11:0] row_prod, col_prod;
    logic [13:0] row_pos, col_pos;
    logic        row_in, col_in;

    logic              st1_valid_reg;
    logic [7:0]        st1_row_reg;
    logic [7:0]        st1_col_reg;
    logic              st1_inside_reg;
    logic [SRC_W-1:0]  st1_base_reg;
    logic [DEST_W-1:0] st1_dest_reg;
    logic              st1_last_reg;

    logic [16:0]       src_prod;
    logic [SRC_W-1:0]  src_sum;

    logic              out_valid_reg;
    logic [SRC_W-1:0]  out_src_reg;
    logic              out_zero_reg;
    logic [DEST_W-1:0] out_dest_reg;
    logic              out_last_reg;

    i2cpag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cpag_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .restart (s_tdata[0]),
        .pos     (pos)
    );

    // Pipeline moves whenever the output slot is free or being taken
    assign enable   = !out_valid_reg || m_tready;
    assign s_tready = enable;
    assign advance  = s_tvalid && enable;

    // Stage 1: padded source row and column
    assign row_prod = pos.orow * cfg.step;
    assign col_prod = pos.ocol * cfg.step;
    assign row_pos  = {2'b00, row_prod} + {10'd0, pos.krow} - {10'd0, cfg.pad};
    assign col_pos  = {2'b00, col_prod} + {10'd0, pos.kcol} - {10'd0, cfg.pad};
    assign row_in   = !row_pos[13] && (row_pos[12:0] < {4'd0, cfg.ih});
    assign col_in   = !col_pos[13] && (col_pos[12:0] < {4'd0, cfg.iw});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_row_reg    <= row_pos[7:0];
            st1_col_reg    <= col_pos[7:0];
            st1_inside_reg <= row_in && col_in;
            st1_base_reg   <= pos.base;
            st1_dest_reg   <= pos.dest;
            st1_last_reg   <= pos.last;
        end
    end

    // Stage 2: flat source index
    assign src_prod = st1_row_reg * cfg.iw;
    assign src_sum  = st1_base_reg + SRC_W'(src_prod) + SRC_W'(st1_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && st1_valid_reg)
        begin
            out_src_reg  <= st1_inside_reg ? src_sum : '0;
            out_zero_reg <= !st1_inside_reg;
            out_dest_reg <= st1_dest_reg;
            out_last_reg <= st1_last_reg;
        end
    end

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_dest_reg, out_src_reg};
    assign m_tuser  = out_zero_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[24:0] == 25'd0))
        else $error("zero-filled word carries a nonzero source index");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stage is stalled");

    a_restart_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s_tdata[0]) |=> (st1_valid_reg && st1_dest_reg == '0))
        else $error("restart did not rewind the destination index");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && pos.last) |=> (pos.dest == '0))
        else $error("position did not wrap after the last element");

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (enable && st1_valid_reg) |=> out_valid_reg)
        else $error("stage 1 word lost on its way to the output");

endmodule
`default_nettype wire
